### rtl/cte_pkg.sv
// Shared types, constants and helpers for the calendar time set editor.
// No dependencies; used by cte_update and calendar_time_set_editor.
package cte_pkg;

  localparam int NUM_FIELDS = 7;

  // Field positions in the time array, also the codes of the selected field
  localparam logic [2:0] FLD_YEAR    = 3'd0;
  localparam logic [2:0] FLD_MONTH   = 3'd1;
  localparam logic [2:0] FLD_DAY     = 3'd2;
  localparam logic [2:0] FLD_HOUR    = 3'd3;
  localparam logic [2:0] FLD_MINUTE  = 3'd4;
  localparam logic [2:0] FLD_SECOND  = 3'd5;
  localparam logic [2:0] FLD_WEEKDAY = 3'd6;

  // Event codes
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_MODE   = 3'd1;
  localparam logic [2:0] OP_SELECT = 3'd2;
  localparam logic [2:0] OP_UP     = 3'd3;
  localparam logic [2:0] OP_DOWN   = 3'd4;
  localparam logic [2:0] OP_LOAD   = 3'd5;

  localparam logic [6:0] YEAR_MAX    = 7'd99;
  localparam logic [6:0] MONTH_MAX   = 7'd12;
  localparam logic [6:0] HOUR_MAX    = 7'd23;
  localparam logic [6:0] MINSEC_MAX  = 7'd59;
  localparam logic [6:0] WEEKDAY_MAX = 7'd7;
  localparam logic [6:0] MONTH_FEB   = 7'd2;

  localparam logic [15:0] BLINK_PERIOD_RST = 16'd500;

  typedef logic [6:0] field_t;
  typedef field_t [NUM_FIELDS-1:0] fields_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [6:0] year_in;
    logic [3:0] month_in;
    logic [4:0] day_in;
    logic [4:0] hour_in;
    logic [5:0] minute_in;
    logic [5:0] second_in;
    logic [2:0] weekday_in;
  } item_t;

  typedef struct packed {
    fields_t     fields;
    logic        editing;
    logic [2:0]  sel;
    logic        blink;
    logic [15:0] tick;
  } state_t;

  typedef struct packed {
    fields_t    fields;
    logic [2:0] sel;
    logic       editing;
    logic       blink;
    logic       commit;
  } result_t;

  // Month length; anything outside 1..12 counts as a 31-day month
  function automatic logic [4:0] days_in_month(input logic [6:0] yr, input logic [6:0] mo);
    logic [4:0] len;
    case (mo)
      7'd4, 7'd6, 7'd9, 7'd11: len = 5'd30;
      MONTH_FEB:               len = (yr[1:0] == 2'b00) ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### rtl/cte_update.sv
// Next-state logic of the calendar time set editor: applies one event to the state.
// Depends on cte_pkg.
module cte_update (
  input  cte_pkg::state_t state_i,
  input  cte_pkg::item_t  item_i,
  input  logic [15:0]     period_i,
  output cte_pkg::state_t state_o,
  output logic            commit_o
);

  cte_pkg::fields_t fields;
  cte_pkg::field_t  step;
  logic [4:0]       mdays;
  logic [15:0]      tick_inc;

  assign tick_inc = state_i.tick + 16'd1;

  always_comb begin
    state_o  = state_i;
    commit_o = 1'b0;
    fields   = state_i.fields;
    mdays    = 5'd31;
    step     = (item_i.opcode == cte_pkg::OP_UP) ? 7'd1 : 7'h7F;

    // bump the selected field with 7-bit wrap, then check every field
    for (int k = 0; k < cte_pkg::NUM_FIELDS; k++) begin
      if (state_i.sel == 3'(k)) begin
        fields[k] = fields[k] + step;
      end
    end

    case (item_i.opcode)
      cte_pkg::OP_TICK: begin
        if (tick_inc >= period_i) begin
          state_o.tick  = '0;
          state_o.blink = ~state_i.blink;
        end else begin
          state_o.tick = tick_inc;
        end
      end
      cte_pkg::OP_MODE: begin
        state_o.editing = ~state_i.editing;
        commit_o        = state_i.editing;
      end
      cte_pkg::OP_SELECT: begin
        if (state_i.editing) begin
          state_o.sel = (state_i.sel >= cte_pkg::FLD_WEEKDAY) ? cte_pkg::FLD_YEAR
                                                               : state_i.sel + 3'd1;
        end
      end
      cte_pkg::OP_UP: begin
        if (state_i.editing) begin
          if (fields[cte_pkg::FLD_YEAR] > cte_pkg::YEAR_MAX) fields[cte_pkg::FLD_YEAR] = 7'd0;
          if (fields[cte_pkg::FLD_MONTH] > cte_pkg::MONTH_MAX) fields[cte_pkg::FLD_MONTH] = 7'd1;
          mdays = cte_pkg::days_in_month(fields[cte_pkg::FLD_YEAR], fields[cte_pkg::FLD_MONTH]);
          if (fields[cte_pkg::FLD_DAY] > {2'b00, mdays}) fields[cte_pkg::FLD_DAY] = 7'd1;
          if (fields[cte_pkg::FLD_HOUR] > cte_pkg::HOUR_MAX) fields[cte_pkg::FLD_HOUR] = 7'd0;
          if (fields[cte_pkg::FLD_MINUTE] > cte_pkg::MINSEC_MAX) begin
            fields[cte_pkg::FLD_MINUTE] = 7'd0;
          end
          if (fields[cte_pkg::FLD_SECOND] > cte_pkg::MINSEC_MAX) begin
            fields[cte_pkg::FLD_SECOND] = 7'd0;
          end
          if (fields[cte_pkg::FLD_WEEKDAY] > cte_pkg::WEEKDAY_MAX) begin
            fields[cte_pkg::FLD_WEEKDAY] = 7'd1;
          end
          state_o.fields = fields;
        end
      end
      cte_pkg::OP_DOWN: begin
        if (state_i.editing) begin
          if (fields[cte_pkg::FLD_YEAR] > cte_pkg::YEAR_MAX) begin
            fields[cte_pkg::FLD_YEAR] = cte_pkg::YEAR_MAX;
          end
          if (fields[cte_pkg::FLD_MONTH] == 7'd0) fields[cte_pkg::FLD_MONTH] = cte_pkg::MONTH_MAX;
          mdays = cte_pkg::days_in_month(fields[cte_pkg::FLD_YEAR], fields[cte_pkg::FLD_MONTH]);
          if (fields[cte_pkg::FLD_DAY] == 7'd0) begin
            fields[cte_pkg::FLD_DAY] = {2'b00, mdays};
          end else if (fields[cte_pkg::FLD_DAY] > {2'b00, mdays}) begin
            fields[cte_pkg::FLD_DAY] = 7'd1;
          end
          if (fields[cte_pkg::FLD_HOUR] > cte_pkg::HOUR_MAX) begin
            fields[cte_pkg::FLD_HOUR] = cte_pkg::HOUR_MAX;
          end
          if (fields[cte_pkg::FLD_MINUTE] > cte_pkg::MINSEC_MAX) begin
            fields[cte_pkg::FLD_MINUTE] = cte_pkg::MINSEC_MAX;
          end
          if (fields[cte_pkg::FLD_SECOND] > cte_pkg::MINSEC_MAX) begin
            fields[cte_pkg::FLD_SECOND] = cte_pkg::MINSEC_MAX;
          end
          if (fields[cte_pkg::FLD_WEEKDAY] == 7'd0) begin
            fields[cte_pkg::FLD_WEEKDAY] = cte_pkg::WEEKDAY_MAX;
          end
          state_o.fields = fields;
        end
      end
      cte_pkg::OP_LOAD: begin
        if (!state_i.editing) begin
          state_o.fields[cte_pkg::FLD_YEAR]    = item_i.year_in;
          state_o.fields[cte_pkg::FLD_MONTH]   = {3'b000, item_i.month_in};
          state_o.fields[cte_pkg::FLD_DAY]     = {2'b00, item_i.day_in};
          state_o.fields[cte_pkg::FLD_HOUR]    = {2'b00, item_i.hour_in};
          state_o.fields[cte_pkg::FLD_MINUTE]  = {1'b0, item_i.minute_in};
          state_o.fields[cte_pkg::FLD_SECOND]  = {1'b0, item_i.second_in};
          state_o.fields[cte_pkg::FLD_WEEKDAY] = {4'b0000, item_i.weekday_in};
        end
      end
      default: begin
        // unused codes change nothing
      end
    endcase
  end

endmodule

### rtl/calendar_time_set_editor.sv
// Top level of the calendar time set editor: input register, state, result register.
// Depends on cte_pkg and cte_update.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one event per transaction: a tick,
//   the mode, select, up or down key, or a load of a full time from in_*_in.
//   Result channel (out_valid / out_stall) returns exactly one transaction per
//   event, showing the time, selected field, edit mode and blink phase after
//   that event; out_commit is high on the result of the mode key that leaves
//   edit mode.
//   Configuration: cfg_blink_period is written when cfg_valid is high
//   (cfg_ready is always high); write it only while no event is in flight.
//   An accepted event goes from the input register to the result register;
//   throughput is one event per cycle while out_stall is low, set by the single
//   update stage between the two registers, which also writes the state.
//   Reset (rst_n low, synchronous) empties both registers and restores
//   year 0, month 1, day 1, weekday 1, display mode, blink period 500.
//   When the receiver stalls, the result holds and one more event is taken
//   into the input register; after that in_stall rises until the result leaves.
module calendar_time_set_editor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [6:0]  in_year_in,
  input  logic [3:0]  in_month_in,
  input  logic [4:0]  in_day_in,
  input  logic [4:0]  in_hour_in,
  input  logic [5:0]  in_minute_in,
  input  logic [5:0]  in_second_in,
  input  logic [2:0]  in_weekday_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [2:0]  out_weekday,
  output logic [2:0]  out_selected_field,
  output logic        out_editing,
  output logic        out_blink_on,
  output logic        out_commit,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_blink_period
);

  logic              in_vld_r;
  cte_pkg::item_t    item_r;
  cte_pkg::item_t    item_nxt;
  cte_pkg::state_t   state_r;
  cte_pkg::state_t   state_nxt;
  logic              commit_nxt;
  logic              out_vld_r;
  cte_pkg::result_t  res_r;
  logic [15:0]       period_r;
  logic              out_hold;
  logic              advance;

  assign out_hold  = out_vld_r && out_stall;
  assign advance   = in_vld_r && !out_hold;
  assign in_stall  = in_vld_r && out_hold;
  assign cfg_ready = 1'b1;

  assign item_nxt = '{opcode:     in_opcode,
                      year_in:    in_year_in,
                      month_in:   in_month_in,
                      day_in:     in_day_in,
                      hour_in:    in_hour_in,
                      minute_in:  in_minute_in,
                      second_in:  in_second_in,
                      weekday_in: in_weekday_in};

  cte_update u_update (
    .state_i  (state_r),
    .item_i   (item_r),
    .period_i (period_r),
    .state_o  (state_nxt),
    .commit_o (commit_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      period_r      <= cte_pkg::BLINK_PERIOD_RST;
      // weekday down to year: weekday 1, day 1, month 1, the rest 0
      state_r.fields  <= {7'd1, 7'd0, 7'd0, 7'd0, 7'd1, 7'd1, 7'd0};
      state_r.editing <= 1'b0;
      state_r.sel     <= cte_pkg::FLD_YEAR;
      state_r.blink   <= 1'b0;
      state_r.tick    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        period_r <= cfg_blink_period;
      end
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (!out_hold) begin
        out_vld_r <= in_vld_r;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= item_nxt;
    end
    if (advance) begin
      res_r.fields  <= state_nxt.fields;
      res_r.sel     <= state_nxt.sel;
      res_r.editing <= state_nxt.editing;
      res_r.blink   <= state_nxt.blink;
      res_r.commit  <= commit_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_year           = res_r.fields[cte_pkg::FLD_YEAR];
  assign out_month          = res_r.fields[cte_pkg::FLD_MONTH][3:0];
  assign out_day            = res_r.fields[cte_pkg::FLD_DAY][4:0];
  assign out_hour           = res_r.fields[cte_pkg::FLD_HOUR][4:0];
  assign out_minute         = res_r.fields[cte_pkg::FLD_MINUTE][5:0];
  assign out_second         = res_r.fields[cte_pkg::FLD_SECOND][5:0];
  assign out_weekday        = res_r.fields[cte_pkg::FLD_WEEKDAY][2:0];
  assign out_selected_field = res_r.sel;
  assign out_editing        = res_r.editing;
  assign out_blink_on       = res_r.blink;
  assign out_commit         = res_r.commit;

endmodule
